[design/rit_pkg.sv]
// ----------------------------------------------------------------------------
// rit_pkg
// Shared types, sizes and helpers for the reply impairment timed queue.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAX_FRAME  = 1536;
    localparam int TIME_W     = 48;
    localparam int ORDER_W    = 32;
    localparam int CFG_W      = 32;
    localparam int TAG_W      = 16;
    localparam int LEN_W      = 16;
    localparam int US_TO_NS   = 1000;
    localparam int MUL_W      = CFG_W + 10;
    localparam int ADDR_W     = 5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LATE_DELAY   = 3'd0;
    localparam logic [2:0] REG_LATE_COUNT   = 3'd1;
    localparam logic [2:0] REG_DUP_COUNT    = 3'd2;
    localparam logic [2:0] REG_REORDER_CNT  = 3'd3;
    localparam logic [2:0] REG_HOLD_LIMIT   = 3'd4;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef struct packed {
        logic                late;
        logic                dup;
        logic                reorder;
        logic [CFG_W-1:0]    value;
    } cfg_wr_t;

    typedef struct packed {
        logic                mode;
        logic [TIME_W-1:0]   now_time;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    len;
        logic [TIME_W-1:0]   due;
        logic [TIME_W-1:0]   hold_due;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   idx;
    } pick_t;

    // lowest set bit of a slot vector
    function automatic pick_t lowest_set(input logic [SLOTS-1:0] vec);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                p.found = 1'b1;
                p.idx   = SLOT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

[design/rit_ifs.sv]
// ----------------------------------------------------------------------------
// rit_ifs
// Valid/ready channels for submit/pop requests and for results.
// ----------------------------------------------------------------------------
interface rit_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [rit_pkg::TIME_W-1:0]    now_time;
    logic [rit_pkg::TAG_W-1:0]     frame_tag;
    logic [rit_pkg::LEN_W-1:0]     frame_length;

    modport source (output valid, mode, now_time, frame_tag, frame_length, input ready);
    modport sink   (input valid, mode, now_time, frame_tag, frame_length, output ready);
endinterface

interface rit_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          popped;
    logic [rit_pkg::TAG_W-1:0]     out_tag;
    logic [rit_pkg::LEN_W-1:0]     out_length;
    logic                          held_alone;
    logic [1:0]                    slots_missed;
    logic [rit_pkg::TIME_W-1:0]    earliest_due;

    modport source (output valid, popped, out_tag, out_length, held_alone, slots_missed,
                    earliest_due, input ready);
    modport sink   (input valid, popped, out_tag, out_length, held_alone, slots_missed,
                    earliest_due, output ready);
endinterface

[design/reply_impairment_timed_queue.sv]
// ----------------------------------------------------------------------------
// reply_impairment_timed_queue
// Timed slot queue of reply descriptors with delay, swap and duplication.
// ----------------------------------------------------------------------------
// A front stage takes a request, clamps the length, forms the release times
// and parks it in a two-entry queue; it takes no new request until that one
// is pushed. The back part then works one item at a time through the eight
// slots with a single compare unit: a submit runs the insert, the duplicate
// and then the earliest-time scan, a pop the due-slot scan, the release and
// the earliest-time scan. The result sits in an output register, so the
// front keeps accepting while it waits to be taken. Configuration is
// written through the APB port at byte address 4*index.
module reply_impairment_timed_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    rit_req_if.sink                       req,
    rit_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rit_pkg::ADDR_W-1:0]    paddr,
    input  logic [rit_pkg::CFG_W-1:0]     pwdata,
    output logic [rit_pkg::CFG_W-1:0]     prdata,
    output logic                          pready
);
    import rit_pkg::*;

    logic [CFG_W-1:0]  late_delay_us_reg;
    logic [CFG_W-1:0]  late_count_reg;
    logic [CFG_W-1:0]  dup_count_reg;
    logic [CFG_W-1:0]  reorder_count_reg;
    logic [CFG_W-1:0]  hold_limit_ns_reg;
    logic              wr;
    logic [2:0]        reg_idx;
    cfg_wr_t           cfg_wr;
    logic              q_push, q_pop, q_full, q_empty;
    item_t             push_item, pop_item;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_wr.late    = wr && (reg_idx == REG_LATE_COUNT);
        cfg_wr.dup     = wr && (reg_idx == REG_DUP_COUNT);
        cfg_wr.reorder = wr && (reg_idx == REG_REORDER_CNT);
        cfg_wr.value   = pwdata;
    end

    always_comb
    begin
        case (reg_idx)
            REG_LATE_DELAY:  prdata = late_delay_us_reg;
            REG_LATE_COUNT:  prdata = late_count_reg;
            REG_DUP_COUNT:   prdata = dup_count_reg;
            REG_REORDER_CNT: prdata = reorder_count_reg;
            REG_HOLD_LIMIT:  prdata = hold_limit_ns_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            late_delay_us_reg <= '0;
            late_count_reg    <= '0;
            dup_count_reg     <= '0;
            reorder_count_reg <= '0;
            hold_limit_ns_reg <= CFG_W'(1000000);
        end
        else if (wr)
        begin
            case (reg_idx)
                REG_LATE_DELAY:  late_delay_us_reg <= pwdata;
                REG_LATE_COUNT:  late_count_reg    <= pwdata;
                REG_DUP_COUNT:   dup_count_reg     <= pwdata;
                REG_REORDER_CNT: reorder_count_reg <= pwdata;
                REG_HOLD_LIMIT:  hold_limit_ns_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    rit_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cfg_wr        (cfg_wr),
        .late_delay_us (late_delay_us_reg),
        .hold_limit_ns (hold_limit_ns_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    rit_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    rit_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .q_empty (q_empty),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

[design/rit_front.sv]
// ----------------------------------------------------------------------------
// rit_front
// Accepts requests, clamps length, applies the late delay and forms the
// release times, then pushes a classified item into the queue.
// ----------------------------------------------------------------------------
module rit_front (
    input  logic                        clk,
    input  logic                        rst_n,
    rit_req_if.sink                     req,
    input  rit_pkg::cfg_wr_t            cfg_wr,
    input  logic [rit_pkg::CFG_W-1:0]   late_delay_us,
    input  logic [rit_pkg::CFG_W-1:0]   hold_limit_ns,
    input  logic                        q_full,
    output logic                        q_push,
    output rit_pkg::item_t              q_item
);
    import rit_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic [CFG_W-1:0]    late_rem_reg, late_rem_next;
    logic                s1_mode_reg;
    logic [TIME_W-1:0]   s1_now_reg;
    logic [TAG_W-1:0]    s1_tag_reg;
    logic [LEN_W-1:0]    s1_len_reg;
    logic [MUL_W-1:0]    s1_prod_reg;
    logic                s1_late_reg;
    logic                accept;
    logic                late_hit;
    logic [LEN_W-1:0]    len_clamped;

    assign req.ready = !s1_valid_reg;
    assign accept    = req.valid && !s1_valid_reg;
    assign late_hit  = (req.mode == MODE_SUBMIT) && (late_rem_reg != '0);
    assign len_clamped = (req.frame_length > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME)
                                                                : req.frame_length;

    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        q_item.mode     = s1_mode_reg;
        q_item.now_time = s1_now_reg;
        q_item.tag      = s1_tag_reg;
        q_item.len      = s1_len_reg;
        q_item.due      = s1_late_reg ? (s1_now_reg + TIME_W'(s1_prod_reg)) : s1_now_reg;
        q_item.hold_due = s1_now_reg + TIME_W'(hold_limit_ns);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        late_rem_next = late_rem_reg;
        if (q_push)
            s1_valid_next = 1'b0;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (late_hit)
                late_rem_next = late_rem_reg - 1'b1;
        end
        if (cfg_wr.late)
            late_rem_next = cfg_wr.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            late_rem_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            late_rem_reg <= late_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= req.mode;
            s1_now_reg  <= req.now_time;
            s1_tag_reg  <= req.frame_tag;
            s1_len_reg  <= len_clamped;
            s1_late_reg <= late_hit;
            s1_prod_reg <= MUL_W'(late_delay_us) * MUL_W'(US_TO_NS);
        end
    end

endmodule

[design/rit_queue.sv]
// ----------------------------------------------------------------------------
// rit_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module rit_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rit_pkg::item_t   push_item,
    input  logic             pop,
    output rit_pkg::item_t   pop_item,
    output logic             full,
    output logic             empty
);
    import rit_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[design/rit_back.sv]
// ----------------------------------------------------------------------------
// rit_back
// Slot store and sequencer: inserts, swaps held replies, duplicates, scans
// for the due reply to release and for the earliest pending time.
// ----------------------------------------------------------------------------
module rit_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rit_pkg::cfg_wr_t    cfg_wr,
    input  logic                q_empty,
    input  rit_pkg::item_t      q_item,
    output logic                q_pop,
    rit_rsp_if.source           rsp
);
    import rit_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUB   = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_PSCAN = 3'd3;
    localparam logic [2:0] ST_PREL  = 3'd4;
    localparam logic [2:0] ST_MSCAN = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [SLOTS-1:0]    held_reg, held_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic [CFG_W-1:0]    dup_rem_reg, dup_rem_next;
    logic [CFG_W-1:0]    reo_rem_reg, reo_rem_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [1:0]          missed_reg, missed_next;
    logic                best_found_reg, best_found_next;
    logic [SLOT_W-1:0]   best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]   best_due_reg, best_due_next;
    logic [ORDER_W-1:0]  best_order_reg, best_order_next;
    logic                min_any_reg, min_any_next;
    logic [TIME_W-1:0]   min_val_reg, min_val_next;
    logic                popped_reg, popped_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                alone_reg, alone_next;
    logic                out_valid_reg, out_valid_next;
    item_t               cur_reg;

    logic [TIME_W-1:0]   slot_due   [SLOTS];
    logic [ORDER_W-1:0]  slot_order [SLOTS];
    logic [TAG_W-1:0]    slot_tag   [SLOTS];
    logic [LEN_W-1:0]    slot_len   [SLOTS];

    // slot write ports
    logic                ins_en;
    logic [SLOT_W-1:0]   ins_idx;
    logic [TIME_W-1:0]   ins_due;
    logic                swap_en;
    logic [SLOT_W-1:0]   swap_idx;
    logic [ORDER_W-1:0]  swap_order;

    pick_t               free_pick, held_pick;
    logic                last;
    logic                out_load;
    logic [TIME_W-1:0]   scan_due;
    logic [ORDER_W-1:0]  scan_order;

    assign free_pick  = lowest_set(~used_reg);
    assign held_pick  = lowest_set(used_reg & held_reg);
    assign last       = (idx_reg == SLOT_W'(SLOTS - 1));
    assign scan_due   = slot_due[idx_reg];
    assign scan_order = slot_order[idx_reg];
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        held_next       = held_reg;
        order_next      = order_reg;
        dup_rem_next    = dup_rem_reg;
        reo_rem_next    = reo_rem_reg;
        idx_next        = idx_reg;
        missed_next     = missed_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_due_next   = best_due_reg;
        best_order_next = best_order_reg;
        min_any_next    = min_any_reg;
        min_val_next    = min_val_reg;
        popped_next     = popped_reg;
        tag_next        = tag_reg;
        len_next        = len_reg;
        alone_next      = alone_reg;
        out_valid_next  = out_valid_reg;
        ins_en          = 1'b0;
        ins_idx         = free_pick.idx;
        ins_due         = cur_reg.due;
        swap_en         = 1'b0;
        swap_idx        = held_pick.idx;
        swap_order      = order_reg;

        if (rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    missed_next     = '0;
                    popped_next     = 1'b0;
                    tag_next        = '0;
                    len_next        = '0;
                    alone_next      = 1'b0;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    min_any_next    = 1'b0;
                    state_next      = (q_item.mode == MODE_POP) ? ST_PSCAN : ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (held_pick.found)
                begin
                    // insert the partner, then re-time the held reply behind it
                    ins_en     = free_pick.found;
                    swap_en    = 1'b1;
                    swap_order = order_reg + ORDER_W'(free_pick.found);
                    order_next = swap_order + 1'b1;
                    held_next[held_pick.idx] = 1'b0;
                end
                else
                begin
                    ins_en = free_pick.found;
                    if (reo_rem_reg != '0)
                    begin
                        ins_due      = cur_reg.hold_due;
                        reo_rem_next = reo_rem_reg - 1'b1;
                        if (free_pick.found)
                            held_next[free_pick.idx] = 1'b1;
                    end
                    else if (free_pick.found)
                        held_next[free_pick.idx] = 1'b0;
                    if (free_pick.found)
                        order_next = order_reg + 1'b1;
                end
                if (free_pick.found)
                begin
                    used_next[free_pick.idx] = 1'b1;
                    if (held_pick.found)
                        held_next[free_pick.idx] = 1'b0;
                end
                else
                    missed_next = missed_reg + 2'd1;
                state_next = ST_DUP;
            end
            ST_DUP:
            begin
                if (dup_rem_reg != '0)
                begin
                    dup_rem_next = dup_rem_reg - 1'b1;
                    if (free_pick.found)
                    begin
                        ins_en     = 1'b1;
                        order_next = order_reg + 1'b1;
                        used_next[free_pick.idx] = 1'b1;
                        held_next[free_pick.idx] = 1'b0;
                    end
                    else
                        missed_next = missed_reg + 2'd1;
                end
                state_next = ST_MSCAN;
            end
            ST_PSCAN:
            begin
                if (used_reg[idx_reg] && (scan_due <= cur_reg.now_time))
                begin
                    if (!best_found_reg || (scan_due < best_due_reg) ||
                        ((scan_due == best_due_reg) && (scan_order < best_order_reg)))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = idx_reg;
                        best_due_next   = scan_due;
                        best_order_next = scan_order;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_PREL;
                end
            end
            ST_PREL:
            begin
                if (best_found_reg)
                begin
                    popped_next = 1'b1;
                    tag_next    = slot_tag[best_idx_reg];
                    len_next    = slot_len[best_idx_reg];
                    alone_next  = held_reg[best_idx_reg];
                    used_next[best_idx_reg] = 1'b0;
                    held_next[best_idx_reg] = 1'b0;
                end
                state_next = ST_MSCAN;
            end
            ST_MSCAN:
            begin
                if (used_reg[idx_reg] && (!min_any_reg || (scan_due < min_val_reg)))
                begin
                    min_any_next = 1'b1;
                    min_val_next = scan_due;
                end
                idx_next = idx_reg + 1'b1;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr.dup)
            dup_rem_next = cfg_wr.value;
        if (cfg_wr.reorder)
            reo_rem_next = cfg_wr.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            held_reg      <= '0;
            order_reg     <= '0;
            dup_rem_reg   <= '0;
            reo_rem_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            held_reg      <= held_next;
            order_reg     <= order_next;
            dup_rem_reg   <= dup_rem_next;
            reo_rem_reg   <= reo_rem_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        missed_reg     <= missed_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_due_reg   <= best_due_next;
        best_order_reg <= best_order_next;
        min_any_reg    <= min_any_next;
        min_val_reg    <= min_val_next;
        popped_reg     <= popped_next;
        tag_reg        <= tag_next;
        len_reg        <= len_next;
        alone_reg      <= alone_next;
        if (q_pop)
            cur_reg <= q_item;
        if (ins_en)
        begin
            slot_due[ins_idx]   <= ins_due;
            slot_order[ins_idx] <= order_reg;
            slot_tag[ins_idx]   <= cur_reg.tag;
            slot_len[ins_idx]   <= cur_reg.len;
        end
        if (swap_en)
        begin
            slot_due[swap_idx]   <= cur_reg.due;
            slot_order[swap_idx] <= swap_order;
        end
        if (out_load)
        begin
            rsp.popped       <= popped_reg;
            rsp.out_tag      <= tag_reg;
            rsp.out_length   <= len_reg;
            rsp.held_alone   <= alone_reg;
            rsp.slots_missed <= missed_reg;
            rsp.earliest_due <= min_any_reg ? min_val_reg : '0;
        end
    end

    assign rsp.valid = out_valid_reg;

endmodule

[tb/rit_queue_board.sv]
// ----------------------------------------------------------------------------
// rit_queue_board
// Predicts the timed reply queue and checks each result beat against it.
// ----------------------------------------------------------------------------
package rit_queue_board;

    import rit_pkg::*;

    typedef struct {
        logic              popped;
        logic [TAG_W-1:0]  out_tag;
        logic [LEN_W-1:0]  out_length;
        logic              held_alone;
        logic [1:0]        slots_missed;
        logic [TIME_W-1:0] earliest_due;
    } reply_t;

    class reply_queue_board;
        logic [CFG_W-1:0]   late_delay_us;
        logic [CFG_W-1:0]   hold_limit_ns;
        logic [CFG_W-1:0]   late_budget;
        logic [CFG_W-1:0]   dup_budget;
        logic [CFG_W-1:0]   swap_left;
        logic [ORDER_W-1:0] next_order;
        logic               used [SLOTS];
        logic               held [SLOTS];
        logic [TIME_W-1:0]  due_at [SLOTS];
        logic [ORDER_W-1:0] order [SLOTS];
        logic [TAG_W-1:0]   tag [SLOTS];
        logic [LEN_W-1:0]   len [SLOTS];
        reply_t             pending[$];
        int                 errors;
        int                 pops_seen;
        int                 misses_seen;
        int                 alone_seen;

        function new();
            late_delay_us = '0;
            hold_limit_ns = 32'd1000000;
            late_budget   = '0;
            dup_budget    = '0;
            swap_left     = '0;
            next_order    = '0;
            errors        = 0;
            pops_seen     = 0;
            misses_seen   = 0;
            alone_seen    = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                used[i] = 1'b0;
                held[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_LATE_DELAY:  late_delay_us = v;
                REG_LATE_COUNT:  late_budget = v;
                REG_DUP_COUNT:   dup_budget = v;
                REG_REORDER_CNT: swap_left = v;
                REG_HOLD_LIMIT:  hold_limit_ns = v;
                default: ;
            endcase
        endfunction

        function bit place(logic [TAG_W-1:0] t, logic [LEN_W-1:0] l,
                           logic [TIME_W-1:0] d, logic h);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!used[i])
                begin
                    used[i]   = 1'b1;
                    held[i]   = h;
                    tag[i]    = t;
                    len[i]    = l;
                    due_at[i] = d;
                    order[i]  = next_order;
                    next_order++;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(logic mode, logic [TIME_W-1:0] now,
                                   logic [TAG_W-1:0] t, logic [LEN_W-1:0] l_in);
            reply_t r;
            logic [TIME_W-1:0] d;
            logic [LEN_W-1:0] l;
            logic [TIME_W-1:0] m;
            int hs;
            int best;
            bit any;
            r = '{default: '0};
            if (mode == MODE_SUBMIT)
            begin
                l = (l_in > MAX_FRAME) ? LEN_W'(MAX_FRAME) : l_in;
                d = now;
                if (late_budget != 0)
                begin
                    d = now + TIME_W'(late_delay_us) * TIME_W'(US_TO_NS);
                    late_budget--;
                end
                hs = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (used[i] && held[i])
                        hs = i;
                if (hs >= 0)
                begin
                    if (!place(t, l, d, 1'b0))
                        r.slots_missed++;
                    held[hs]   = 1'b0;
                    due_at[hs] = d;
                    order[hs]  = next_order;
                    next_order++;
                end
                else if (swap_left != 0)
                begin
                    if (!place(t, l, now + TIME_W'(hold_limit_ns), 1'b1))
                        r.slots_missed++;
                    swap_left--;
                end
                else if (!place(t, l, d, 1'b0))
                    r.slots_missed++;
                if (dup_budget != 0)
                begin
                    if (!place(t, l, d, 1'b0))
                        r.slots_missed++;
                    dup_budget--;
                end
            end
            else
            begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!used[i] || due_at[i] > now)
                        continue;
                    if (best < 0 || due_at[i] < due_at[best] ||
                        (due_at[i] == due_at[best] && order[i] < order[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    r.popped     = 1'b1;
                    r.out_tag    = tag[best];
                    r.out_length = len[best];
                    r.held_alone = held[best];
                    used[best]   = 1'b0;
                    held[best]   = 1'b0;
                end
            end
            any = 0;
            m = '0;
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && (!any || due_at[i] < m))
                begin
                    m = due_at[i];
                    any = 1;
                end
            r.earliest_due = m;
            pending.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t w;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.popped !== w.popped)
            begin
                $error("popped: expected %0h actual %0h", w.popped, got.popped);
                errors++;
            end
            if (got.out_tag !== w.out_tag)
            begin
                $error("out_tag: expected %0h actual %0h", w.out_tag, got.out_tag);
                errors++;
            end
            if (got.out_length !== w.out_length)
            begin
                $error("out_length: expected %0h actual %0h", w.out_length, got.out_length);
                errors++;
            end
            if (got.held_alone !== w.held_alone)
            begin
                $error("held_alone: expected %0h actual %0h", w.held_alone, got.held_alone);
                errors++;
            end
            if (got.slots_missed !== w.slots_missed)
            begin
                $error("slots_missed: expected %0h actual %0h",
                       w.slots_missed, got.slots_missed);
                errors++;
            end
            if (got.earliest_due !== w.earliest_due)
            begin
                $error("earliest_due: expected %0h actual %0h",
                       w.earliest_due, got.earliest_due);
                errors++;
            end
            pops_seen   += w.popped;
            misses_seen += (w.slots_missed != 0);
            alone_seen  += w.held_alone;
        endfunction
    endclass

endpackage

[tb/reply_impairment_timed_queue_test.sv]
// ----------------------------------------------------------------------------
// reply_impairment_timed_queue_test
// Drives submit and pop beats with random gaps, writes the impairment
// registers between phases, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module reply_impairment_timed_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rit_pkg::*;
    import rit_queue_board::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0] pwdata;
    logic [CFG_W-1:0] prdata;
    logic pready;

    rit_req_if req_ch ();
    rit_rsp_if rsp_ch ();

    reply_impairment_timed_queue u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reply_queue_board board;
    logic [TIME_W-1:0] clock_ns;
    int idle_cycles;
    int items_sent;
    bit hold_off;
    bit stim_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    endfunction

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        reply_t got;
        int g;
        rsp_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_off)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (g > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.popped       = rsp_ch.popped;
                got.out_tag      = rsp_ch.out_tag;
                got.out_length   = rsp_ch.out_length;
                got.held_alone   = rsp_ch.held_alone;
                got.slots_missed = rsp_ch.slots_missed;
                got.earliest_due = rsp_ch.earliest_due;
                board.check_reply(got);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !hold_off)
        begin
            $display("reply_impairment_timed_queue_test: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, v);
    endtask

    task automatic send(logic mode, logic [TIME_W-1:0] now,
                        logic [TAG_W-1:0] t, logic [LEN_W-1:0] l, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.now_time     <= now;
        req_ch.frame_tag    <= t;
        req_ch.frame_length <= l;
        @(posedge clk iff req_ch.ready);
        board.note_request(mode, now, t, l);
        items_sent++;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    // mostly advancing clock, with pops that usually find something due
    task automatic random_phase(int n);
        logic [TIME_W-1:0] now;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                now = rand_time();
            else
            begin
                clock_ns = clock_ns + $urandom_range(0, 3000);
                now = clock_ns;
            end
            send(($urandom_range(0, 99) < 48) ? MODE_POP : MODE_SUBMIT,
                 ($urandom_range(0, 3) == 0) ? now + TIME_W'(2000000) : now,
                 16'($urandom()),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1600)),
                 1'b1);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_SUBMIT;
        req_ch.now_time = '0;
        req_ch.frame_tag = '0;
        req_ch.frame_length = '0;
        clock_ns = 48'd1000;
        items_sent = 0;
        hold_off = 0;
        stim_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, pops on empty, overflow, zero due
        send(MODE_POP, '0, '0, '0, 1'b0);
        send(MODE_SUBMIT, '0, 16'hFFFF, 16'hFFFF, 1'b0);
        send(MODE_SUBMIT, 48'hFFFF_FFFF_FFFF, 16'h0000, 16'd0, 1'b0);
        send(MODE_SUBMIT, 48'd500, 16'h1234, 16'd1536, 1'b0);
        send(MODE_SUBMIT, 48'd500, 16'h4321, 16'd1537, 1'b0);
        for (int k = 0; k < 6; k++)
            send(MODE_SUBMIT, 48'd700, 16'(k), 16'(k * 300), 1'b0);
        for (int k = 0; k < 9; k++)
            send(MODE_POP, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0);
        settle();

        // swap with held reply, duplication, delay, then an orphaned hold
        write_reg(REG_LATE_DELAY, 32'd5);
        write_reg(REG_LATE_COUNT, 32'd2);
        write_reg(REG_DUP_COUNT, 32'd1);
        write_reg(REG_REORDER_CNT, 32'd2);
        write_reg(REG_HOLD_LIMIT, 32'd0);
        send(MODE_SUBMIT, 48'd100, 16'hA001, 16'd64, 1'b0);
        send(MODE_SUBMIT, 48'd100, 16'hA002, 16'd64, 1'b0);
        send(MODE_SUBMIT, 48'd200, 16'hA003, 16'd64, 1'b0);
        for (int k = 0; k < 5; k++)
            send(MODE_POP, 48'd20000, '0, '0, 1'b0);
        settle();

        // extremes of the registers, wrap of the delayed due time
        write_reg(REG_LATE_DELAY, 32'hFFFF_FFFF);
        write_reg(REG_LATE_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_DUP_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_REORDER_CNT, 32'hFFFF_FFFF);
        write_reg(REG_HOLD_LIMIT, 32'hFFFF_FFFF);
        random_phase(150);
        settle();

        write_reg(REG_LATE_DELAY, 32'd3);
        write_reg(REG_LATE_COUNT, 32'd40);
        write_reg(REG_DUP_COUNT, 32'd30);
        write_reg(REG_REORDER_CNT, 32'd50);
        write_reg(REG_HOLD_LIMIT, 32'd1000000);
        random_phase(200);

        // hold the result side off while requests keep coming
        hold_off = 1;
        random_phase(60);
        settle();

        write_reg(REG_LATE_COUNT, 32'd0);
        write_reg(REG_DUP_COUNT, 32'd0);
        write_reg(REG_REORDER_CNT, 32'd0);
        write_reg(REG_HOLD_LIMIT, 32'd1);
        random_phase(150);
        settle();

        write_reg(REG_LATE_DELAY, 32'd1);
        write_reg(REG_LATE_COUNT, 32'd1000);
        write_reg(REG_DUP_COUNT, 32'd7);
        write_reg(REG_REORDER_CNT, 32'd1000);
        random_phase(150);
        settle();

        $display("covered %0d requests: %0d releases, %0d overflowing submits, %0d orphan holds",
                 items_sent, board.pops_seen, board.misses_seen, board.alone_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("reply_impairment_timed_queue_test: clean");
        else
            $display("reply_impairment_timed_queue_test: errors");
        $finish;
    end

endmodule

[filelist.f]
design/rit_pkg.sv
design/rit_ifs.sv
design/rit_front.sv
design/rit_queue.sv
design/rit_back.sv
design/reply_impairment_timed_queue.sv
tb/rit_queue_board.sv
tb/reply_impairment_timed_queue_test.sv
